// ===== design/tsm_pkg.sv =====
// shared types and constants of the two-way sorted merge
`timescale 1ns / 1ps
`default_nettype none

package tsm_pkg;

    localparam int CMDQ_DEPTH = 4;
    localparam int OUTQ_DEPTH = 4;

    localparam logic KIND_A = 1'b0;
    localparam logic KIND_B = 1'b1;

    typedef enum logic {
        OP_MARK = 1'b0,
        OP_ELEM = 1'b1
    } op_t;

    typedef struct packed {
        op_t  op;
        logic kind;
        logic is_last;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic dropped;
    } res_flags_t;

endpackage

`default_nettype wire

// ===== design/tsm_fifo.sv =====
// small register queue used between the merge stages
`timescale 1ns / 1ps
`default_nettype none

module tsm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      dout,
    output logic                  empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign dout    = data_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

// ===== design/tsm_front.sv =====
// front end: accepts requests, classifies them and queues commands
`timescale 1ns / 1ps
`default_nettype none

module tsm_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          kind,
    input  wire logic signed [VALUE_WIDTH-1:0] elem_value,
    input  wire logic                          has_value,
    input  wire logic                          is_last,
    input  wire logic                          push,
    output logic                               full,
    output logic                               cmd_valid,
    output tsm_pkg::cmd_t                      cmd,
    output logic signed [VALUE_WIDTH-1:0]      cmd_value,
    input  wire logic                          cmd_take
);

    import tsm_pkg::*;

    localparam int QW = $bits(cmd_t) + VALUE_WIDTH;

    cmd_t          cmd_in;
    logic          keep;
    logic          q_full;
    logic          q_empty;
    logic [QW-1:0] q_dout;

    // a request with neither element nor end flag has no effect
    assign keep = has_value || is_last;

    always_comb
    begin
        cmd_in.op      = has_value ? OP_ELEM : OP_MARK;
        cmd_in.kind    = kind;
        cmd_in.is_last = is_last;
    end

    tsm_fifo #(
        .WIDTH (QW),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && keep),
        .din   ({cmd_in, elem_value}),
        .full  (q_full),
        .pop   (cmd_take),
        .dout  (q_dout),
        .empty (q_empty)
    );

    assign full      = q_full;
    assign cmd_valid = !q_empty;
    assign cmd       = cmd_t'(q_dout[QW-1:VALUE_WIDTH]);
    assign cmd_value = q_dout[VALUE_WIDTH-1:0];

endmodule

`default_nettype wire

// ===== design/tsm_back.sv =====
// back end: per-sequence queues, merge compare and result queue
`timescale 1ns / 1ps
`default_nettype none

module tsm_back #(
    parameter int QUEUE_DEPTH = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    input  wire tsm_pkg::cmd_t                 cmd,
    input  wire logic signed [VALUE_WIDTH-1:0] cmd_value,
    output logic                               cmd_take,
    output logic signed [VALUE_WIDTH-1:0]      out_value,
    output logic                               out_valid,
    output logic                               out_last,
    output logic                               dropped,
    output logic                               empty,
    input  wire logic                          pop
);

    import tsm_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int RW = $bits(res_flags_t) + VALUE_WIDTH;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SETTLE = 2'd1;
    localparam logic [1:0] ST_MERGE  = 2'd2;

    logic [1:0] state_reg, state_next;

    logic signed [VALUE_WIDTH-1:0] qa_mem_reg [QUEUE_DEPTH];
    logic signed [VALUE_WIDTH-1:0] qb_mem_reg [QUEUE_DEPTH];
    logic signed [VALUE_WIDTH-1:0] head_a_reg, head_b_reg;

    logic [PW-1:0] wr_a_reg, wr_a_next, rd_a_reg, rd_a_next;
    logic [PW-1:0] wr_b_reg, wr_b_next, rd_b_reg, rd_b_next;
    logic [CW-1:0] cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic          done_a_reg, done_a_next, done_b_reg, done_b_next;
    logic          wr_a_en, wr_b_en;

    logic          sel_done;
    logic [CW-1:0] sel_cnt;
    logic          is_elem;
    logic          drop;
    logic          store;
    logic          set_done;

    logic          both;
    logic          a_less;
    logic          take_a;
    logic          take_b;
    logic [CW-1:0] cnt_a_after, cnt_b_after;

    logic                          res_push;
    logic signed [VALUE_WIDTH-1:0] res_value;
    res_flags_t                    res_flags;
    logic                          res_full;
    logic [RW-1:0]                 res_dout;
    res_flags_t                    out_flags;

    // command classification against the current queue state
    assign sel_done = (cmd.kind == KIND_B) ? done_b_reg : done_a_reg;
    assign sel_cnt  = (cmd.kind == KIND_B) ? cnt_b_reg : cnt_a_reg;
    assign is_elem  = (cmd.op == OP_ELEM);
    assign drop     = is_elem && (sel_done || (sel_cnt == CW'(QUEUE_DEPTH)));
    assign store    = is_elem && !drop;
    assign set_done = !sel_done && cmd.is_last;

    // head selection, ties go to b
    assign both   = (cnt_a_reg != '0) && (cnt_b_reg != '0);
    assign a_less = (head_a_reg < head_b_reg);
    assign take_a = both ? a_less
                  : ((cnt_b_reg == '0) && done_b_reg && (cnt_a_reg != '0)
                     && (done_a_reg || (cnt_a_reg > CW'(1))));
    assign take_b = both ? !a_less
                  : ((cnt_a_reg == '0) && done_a_reg && (cnt_b_reg != '0)
                     && (done_b_reg || (cnt_b_reg > CW'(1))));
    assign cnt_a_after = take_a ? cnt_a_reg - 1'b1 : cnt_a_reg;
    assign cnt_b_after = take_b ? cnt_b_reg - 1'b1 : cnt_b_reg;

    always_comb
    begin
        state_next  = state_reg;
        wr_a_next   = wr_a_reg;
        rd_a_next   = rd_a_reg;
        wr_b_next   = wr_b_reg;
        rd_b_next   = rd_b_reg;
        cnt_a_next  = cnt_a_reg;
        cnt_b_next  = cnt_b_reg;
        done_a_next = done_a_reg;
        done_b_next = done_b_reg;
        wr_a_en     = 1'b0;
        wr_b_en     = 1'b0;
        cmd_take    = 1'b0;
        res_push    = 1'b0;
        res_value   = '0;
        res_flags   = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && !res_full)
                begin
                    cmd_take   = 1'b1;
                    state_next = ST_SETTLE;
                    if (drop)
                    begin
                        res_push          = 1'b1;
                        res_flags.dropped = 1'b1;
                    end
                    if (store && (cmd.kind == KIND_B))
                    begin
                        wr_b_en    = 1'b1;
                        wr_b_next  = (wr_b_reg == PW'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_b_reg + 1'b1;
                        cnt_b_next = cnt_b_reg + 1'b1;
                    end
                    else if (store)
                    begin
                        wr_a_en    = 1'b1;
                        wr_a_next  = (wr_a_reg == PW'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_a_reg + 1'b1;
                        cnt_a_next = cnt_a_reg + 1'b1;
                    end
                    if (set_done && (cmd.kind == KIND_B))
                    begin
                        done_b_next = 1'b1;
                    end
                    else if (set_done)
                    begin
                        done_a_next = 1'b1;
                    end
                end
            end
            ST_SETTLE:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if (take_a || take_b)
                begin
                    if (!res_full)
                    begin
                        res_push        = 1'b1;
                        res_value       = take_a ? head_a_reg : head_b_reg;
                        res_flags.valid = 1'b1;
                        res_flags.last  = done_a_reg && done_b_reg
                                          && (cnt_a_after == '0) && (cnt_b_after == '0);
                        cnt_a_next      = cnt_a_after;
                        cnt_b_next      = cnt_b_after;
                        if (take_a)
                        begin
                            rd_a_next = (rd_a_reg == PW'(QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_a_reg + 1'b1;
                        end
                        else
                        begin
                            rd_b_next = (rd_b_reg == PW'(QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_b_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    if (done_a_reg && done_b_reg && (cnt_a_reg == '0) && (cnt_b_reg == '0))
                    begin
                        done_a_next = 1'b0;
                        done_b_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wr_a_reg   <= '0;
            rd_a_reg   <= '0;
            wr_b_reg   <= '0;
            rd_b_reg   <= '0;
            cnt_a_reg  <= '0;
            cnt_b_reg  <= '0;
            done_a_reg <= 1'b0;
            done_b_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wr_a_reg   <= wr_a_next;
            rd_a_reg   <= rd_a_next;
            wr_b_reg   <= wr_b_next;
            rd_b_reg   <= rd_b_next;
            cnt_a_reg  <= cnt_a_next;
            cnt_b_reg  <= cnt_b_next;
            done_a_reg <= done_a_next;
            done_b_reg <= done_b_next;
        end
    end

    // element queues, head read registered from the next read pointer
    always_ff @(posedge clk)
    begin
        if (wr_a_en)
        begin
            qa_mem_reg[wr_a_reg] <= cmd_value;
        end
        head_a_reg <= qa_mem_reg[rd_a_next];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b_en)
        begin
            qb_mem_reg[wr_b_reg] <= cmd_value;
        end
        head_b_reg <= qb_mem_reg[rd_b_next];
    end

    tsm_fifo #(
        .WIDTH (RW),
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   ({res_value, res_flags}),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_dout),
        .empty (empty)
    );

    assign out_value = res_dout[RW-1:$bits(res_flags_t)];
    assign out_flags = res_flags_t'(res_dout[$bits(res_flags_t)-1:0]);
    assign out_valid = out_flags.valid;
    assign out_last  = out_flags.last;
    assign dropped   = out_flags.dropped;

endmodule

`default_nettype wire

// ===== design/two_way_sorted_merge_top.sv =====
// top level of the two-way merge of sorted sequences
// Input channel: a request carries kind (0 = sequence a, 1 = sequence b), elem_value,
// has_value and is_last; it is taken when push is high and full is low.
// Result channel: the oldest result sits on out_value, out_valid, out_last and dropped
// while empty is low; it is taken when pop is high and empty is low.
// A request with an element or end flag lands in a four-entry command queue.
// The merge engine takes one command, stores the element in its sequence queue or
// reports a drop, records any end flag, passes a settle state for the queue head
// read, then emits one merged element per cycle while the result queue is not full,
// from a single compare of the two registered heads, and returns to idle when
// nothing is left to emit. It takes the next command only from idle; a drop report
// enters the result queue in the cycle the command is taken.
// Results go through a four-entry result queue; when the receiver stalls and that
// queue fills, the engine holds, the command queue fills, and full rises.
// Reset empties both sequence queues and the small queues and clears the end flags
// at once; requests are taken as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module two_way_sorted_merge_top #(
    parameter int QUEUE_DEPTH = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          kind,
    input  wire logic signed [VALUE_WIDTH-1:0] elem_value,
    input  wire logic                          has_value,
    input  wire logic                          is_last,
    input  wire logic                          push,
    output logic                               full,
    output logic signed [VALUE_WIDTH-1:0]      out_value,
    output logic                               out_valid,
    output logic                               out_last,
    output logic                               dropped,
    output logic                               empty,
    input  wire logic                          pop
);

    import tsm_pkg::*;

    logic                          cmd_valid;
    cmd_t                          cmd;
    logic signed [VALUE_WIDTH-1:0] cmd_value;
    logic                          cmd_take;

    tsm_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .kind       (kind),
        .elem_value (elem_value),
        .has_value  (has_value),
        .is_last    (is_last),
        .push       (push),
        .full       (full),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_value  (cmd_value),
        .cmd_take   (cmd_take)
    );

    tsm_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_value (cmd_value),
        .cmd_take  (cmd_take),
        .out_value (out_value),
        .out_valid (out_valid),
        .out_last  (out_last),
        .dropped   (dropped),
        .empty     (empty),
        .pop       (pop)
    );

    // a result is either a merged element or a drop report
    a_valid_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_valid != dropped))
        else $error("result is neither element nor drop report");

    // only a merged element can close a pair
    a_last_is_elem: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_last) |-> out_valid)
        else $error("last flag on a drop report");

    // no request can reach the result side by the edge that sees reset released
    a_empty_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
        else $error("result present right after reset");

    // a command is never taken while the engine sees no command
    a_take_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid)
        else $error("command taken from empty command queue");

endmodule

`default_nettype wire

// ===== tb/sv/merge_order_checker.sv =====
// request and result monitor with merge predictor for the two-way sorted merge
`timescale 1ns / 1ps

module merge_order_checker #(
    parameter int QUEUE_DEPTH = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          kind,
    input  logic signed [VALUE_WIDTH-1:0] elem_value,
    input  logic                          has_value,
    input  logic                          is_last,
    input  logic                          push,
    input  logic                          full,
    input  logic signed [VALUE_WIDTH-1:0] out_value,
    input  logic                          out_valid,
    input  logic                          out_last,
    input  logic                          dropped,
    input  logic                          empty,
    input  logic                          pop,
    output int                            mismatch_count,
    output int                            expect_count,
    output int                            merged_seen,
    output int                            drops_seen
);

    import tsm_pkg::*;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          valid;
        logic                          last;
        logic                          drop;
    } merge_res_t;

    localparam merge_res_t DROP_REPORT = '{value: '0, valid: 1'b0, last: 1'b0, drop: 1'b1};

    merge_res_t                    merged_expect_q[$];
    logic signed [VALUE_WIDTH-1:0] held_a[$];
    logic signed [VALUE_WIDTH-1:0] held_b[$];
    bit                            ended_a;
    bit                            ended_b;
    merge_res_t                    got;
    merge_res_t                    want;
    int                            results_seen;

    task automatic merge_request(input logic k, input logic signed [VALUE_WIDTH-1:0] v,
                                 input logic has, input logic lst);
        merge_res_t r;
        logic       from_b;
        bit         go;
        if ((k == KIND_B && !ended_b) || (k == KIND_A && !ended_a))
        begin
            if (has)
            begin
                if ((k == KIND_B ? held_b.size() : held_a.size()) >= QUEUE_DEPTH)
                    merged_expect_q.push_back(DROP_REPORT);
                else if (k == KIND_B)
                    held_b.push_back(v);
                else
                    held_a.push_back(v);
            end
            if (lst)
            begin
                if (k == KIND_B)
                    ended_b = 1'b1;
                else
                    ended_a = 1'b1;
            end
        end
        else if (has)
        begin
            merged_expect_q.push_back(DROP_REPORT);
        end

        // smaller head first, b wins ties; an open sequence keeps its final element
        go = 1'b1;
        while (go)
        begin
            from_b = 1'b0;
            if (held_a.size() > 0 && held_b.size() > 0)
                from_b = !(held_a[0] < held_b[0]);
            else if (held_a.size() == 0 && ended_a && held_b.size() > 0
                     && (ended_b || held_b.size() > 1))
                from_b = 1'b1;
            else if (held_b.size() == 0 && ended_b && held_a.size() > 0
                     && (ended_a || held_a.size() > 1))
                from_b = 1'b0;
            else
                go = 1'b0;
            if (go)
            begin
                if (from_b)
                    r.value = held_b.pop_front();
                else
                    r.value = held_a.pop_front();
                r.valid = 1'b1;
                r.drop  = 1'b0;
                r.last  = ended_a && ended_b && held_a.size() == 0 && held_b.size() == 0;
                merged_expect_q.push_back(r);
            end
        end

        if (ended_a && ended_b && held_a.size() == 0 && held_b.size() == 0)
        begin
            ended_a = 1'b0;
            ended_b = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                got = '{value: out_value, valid: out_valid, last: out_last, drop: dropped};
                results_seen++;
                if (got.drop)
                    drops_seen++;
                else
                    merged_seen++;
                if (merged_expect_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d unexpected: value %0d valid %b last %b dropped %b",
                                 results_seen, got.value, got.valid, got.last, got.drop);
                end
                else
                begin
                    want = merged_expect_q.pop_front();
                    if (got.value !== want.value || got.valid !== want.valid
                        || got.last !== want.last || got.drop !== want.drop)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("result %0d expected: value %0d valid %b last %b drop %b",
                                     results_seen, want.value, want.valid, want.last,
                                     want.drop);
                            $display("result %0d got:      value %0d valid %b last %b drop %b",
                                     results_seen, got.value, got.valid, got.last, got.drop);
                        end
                    end
                end
            end
            if (push && !full)
                merge_request(kind, elem_value, has_value, is_last);
            expect_count = merged_expect_q.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top: request and result traffic for the two-way sorted merge, and the verdict
`timescale 1ns / 1ps

module tb;
    import tsm_pkg::*;

    localparam int QUEUE_DEPTH = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REQUEST_TARGET = 330;

    localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          kind;
    logic signed [VALUE_WIDTH-1:0] elem_value;
    logic                          has_value;
    logic                          is_last;
    logic                          push;
    logic                          full;
    logic signed [VALUE_WIDTH-1:0] out_value;
    logic                          out_valid;
    logic                          out_last;
    logic                          dropped;
    logic                          empty;
    logic                          pop;

    int mismatch_count;
    int expect_count;
    int merged_seen;
    int drops_seen;

    int cycle_count;
    int requests_sent;
    int pairs_run;
    bit send_fast;
    bit recv_fast;

    logic signed [VALUE_WIDTH-1:0] seqv [0:1][0:63];
    int                            seqn [0:1];

    two_way_sorted_merge_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .kind      (kind),
        .elem_value(elem_value),
        .has_value (has_value),
        .is_last   (is_last),
        .push      (push),
        .full      (full),
        .out_value (out_value),
        .out_valid (out_valid),
        .out_last  (out_last),
        .dropped   (dropped),
        .empty     (empty),
        .pop       (pop)
    );

    merge_order_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .kind          (kind),
        .elem_value    (elem_value),
        .has_value     (has_value),
        .is_last       (is_last),
        .push          (push),
        .full          (full),
        .out_value     (out_value),
        .out_valid     (out_valid),
        .out_last      (out_last),
        .dropped       (dropped),
        .empty         (empty),
        .pop           (pop),
        .mismatch_count(mismatch_count),
        .expect_count  (expect_count),
        .merged_seen   (merged_seen),
        .drops_seen    (drops_seen)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, expect_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_req(input logic k, input logic signed [VALUE_WIDTH-1:0] v,
                            input logic has, input logic lst);
        int gap;
        gap = send_fast ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind       <= k;
        elem_value <= v;
        has_value  <= has;
        is_last    <= lst;
        push       <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
        if (has || lst)
            requests_sent++;
    endtask

    // one pair of sequences, interleaved or one after the other, with late and no-op requests mixed in
    task automatic run_pair(input int len_a, input int len_b, input int vmode,
                            input bit one_first, input logic first_kind);
        int                            idx [0:1];
        bit                            fin [0:1];
        bit                            sep [0:1];
        logic                          k;
        logic                          lst;
        logic signed [VALUE_WIDTH-1:0] key;
        int                            j;
        seqn[KIND_A] = len_a;
        seqn[KIND_B] = len_b;
        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < seqn[s]; i++)
            begin
                case (vmode)
                    1: seqv[s][i] = $urandom_range(0, 20) - 10;
                    2:
                    begin
                        case ($urandom_range(0, 5))
                            0: seqv[s][i] = VAL_MIN;
                            1: seqv[s][i] = VAL_MIN + 1;
                            2: seqv[s][i] = VAL_MAX;
                            3: seqv[s][i] = VAL_MAX - 1;
                            4: seqv[s][i] = 0;
                            default: seqv[s][i] = -1;
                        endcase
                    end
                    default: seqv[s][i] = $urandom;
                endcase
            end
            // mode 3 leaves the values out of order
            if (vmode != 3)
            begin
                for (int i = 1; i < seqn[s]; i++)
                begin
                    key = seqv[s][i];
                    j = i - 1;
                    while (j >= 0 && seqv[s][j] > key)
                    begin
                        seqv[s][j + 1] = seqv[s][j];
                        j--;
                    end
                    seqv[s][j + 1] = key;
                end
            end
            idx[s] = 0;
            fin[s] = 1'b0;
            sep[s] = (seqn[s] == 0) || ($urandom_range(0, 1) == 1);
        end

        while (!(fin[KIND_A] && fin[KIND_B]))
        begin
            if (one_first)
                k = fin[first_kind] ? !first_kind : first_kind;
            else if (fin[KIND_A])
                k = KIND_B;
            else if (fin[KIND_B])
                k = KIND_A;
            else
                k = 1'($urandom_range(0, 1));
            if (idx[k] < seqn[k])
            begin
                lst = (idx[k] == seqn[k] - 1) && !sep[k];
                send_req(k, seqv[k][idx[k]], 1'b1, lst);
                idx[k]++;
                fin[k] = lst;
            end
            else
            begin
                send_req(k, $urandom, 1'b0, 1'b1);
                fin[k] = 1'b1;
            end
            if (fin[k] && !fin[!k] && $urandom_range(0, 3) == 0)
                send_req(k, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if ($urandom_range(0, 15) == 0)
                send_req(1'($urandom_range(0, 1)), $urandom, 1'b0, 1'b0);
        end
        pairs_run++;
    endtask

    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (recv_fast || $urandom_range(0, 9) > 0)
            begin
                if (!recv_fast)
                begin
                    pop <= 1'b0;
                    repeat ($urandom_range(1, 9)) @(negedge clk);
                end
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        int sel;
        int long_len;
        int len_a;
        int len_b;
        int vmode;
        logic long_kind;

        rst_n      = 1'b0;
        kind       = KIND_A;
        elem_value = '0;
        has_value  = 1'b0;
        is_last    = 1'b0;
        push       = 1'b0;
        send_fast  = 1'b0;
        recv_fast  = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // both sequences empty
        send_req(KIND_A, 0, 1'b0, 1'b1);
        send_req(KIND_B, VAL_MAX, 1'b0, 1'b1);
        // extremes and ties
        send_req(KIND_A, VAL_MIN, 1'b1, 1'b0);
        send_req(KIND_B, VAL_MIN, 1'b1, 1'b0);
        send_req(KIND_B, 0, 1'b1, 1'b0);
        send_req(KIND_A, VAL_MAX, 1'b1, 1'b1);
        send_req(KIND_B, VAL_MAX, 1'b1, 1'b0);
        send_req(KIND_B, 32'sh5555aaaa, 1'b0, 1'b1);
        // late element, repeated end flag and no-op request while b is open
        send_req(KIND_A, 5, 1'b1, 1'b1);
        send_req(KIND_A, 7, 1'b1, 1'b0);
        send_req(KIND_A, 8, 1'b1, 1'b1);
        send_req(KIND_A, -1, 1'b0, 1'b1);
        send_req(KIND_B, -1, 1'b0, 1'b0);
        send_req(KIND_B, 3, 1'b1, 1'b0);
        send_req(KIND_B, 9, 1'b1, 1'b1);
        // a empty, b drains
        send_req(KIND_A, 0, 1'b0, 1'b1);
        send_req(KIND_B, -2, 1'b1, 1'b0);
        send_req(KIND_B, 1, 1'b1, 1'b0);
        send_req(KIND_B, 4, 1'b1, 1'b1);

        while (requests_sent < REQUEST_TARGET)
        begin
            send_fast = ($urandom_range(0, 3) == 0);
            recv_fast = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 19);
            vmode = (sel == 0) ? 3 : (sel <= 5) ? 1 : (sel <= 8) ? 2 : 0;
            sel = $urandom_range(0, 99);
            if (sel < 4)
            begin
                // overfill one queue before the other sequence starts
                long_kind = 1'($urandom_range(0, 1));
                long_len  = $urandom_range(QUEUE_DEPTH + 1, QUEUE_DEPTH + 4);
                len_a = (long_kind == KIND_A) ? long_len : $urandom_range(0, 4);
                len_b = (long_kind == KIND_B) ? long_len : $urandom_range(0, 4);
                run_pair(len_a, len_b, vmode, 1'b1, long_kind);
            end
            else if (sel < 14)
            begin
                run_pair($urandom_range(0, 20), $urandom_range(0, 20), vmode,
                         $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
            end
            else
            begin
                run_pair($urandom_range(0, 6), $urandom_range(0, 6), vmode,
                         $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
            end
        end
        push <= 1'b0;

        while (expect_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);

        $display("sent %0d requests: 4 directed cases and %0d random sequence pairs",
                 requests_sent, pairs_run);
        $display("checked %0d merged elements and %0d drop reports, %0d mismatches",
                 merged_seen, drops_seen, mismatch_count);
        if (mismatch_count == 0 && expect_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tsm_pkg.sv
design/tsm_fifo.sv
design/tsm_front.sv
design/tsm_back.sv
design/two_way_sorted_merge_top.sv
tb/sv/merge_order_checker.sv
tb/sv/tb.sv
